[rtl/kde_pkg.sv]
// Package for the key debounce event machine.
// Holds state and event codes, field widths and the step result struct.
// No dependencies.
package kde_pkg;

    localparam int CODE_W = 8;
    localparam int KIND_W = 2;
    localparam int MASK_W = 4;

    typedef enum logic [2:0] {
        ST_INIT       = 3'd0,
        ST_PRESS_FILT = 3'd1,
        ST_PRESS_EDGE = 3'd2,
        ST_PRESSED    = 3'd3,
        ST_REL_FILT   = 3'd4,
        ST_REL_EDGE   = 3'd5,
        ST_RELEASED   = 3'd6
    } kde_state_t;

    typedef enum logic [KIND_W-1:0] {
        EV_PRESS_EDGE = 2'd0,
        EV_PRESS_HOLD = 2'd1,
        EV_REL_EDGE   = 2'd2,
        EV_REL_HOLD   = 2'd3
    } kde_kind_t;

    localparam int MB_PRESS_EDGE = 0;
    localparam int MB_PRESS_HOLD = 1;
    localparam int MB_REL_EDGE   = 2;
    localparam int MB_REL_HOLD   = 3;

    typedef struct packed {
        logic              valid;
        kde_kind_t         kind;
        logic [CODE_W-1:0] code;
    } kde_event_t;

endpackage

[rtl/kde_if.sv]
// Channel interfaces: scan input, event output and trigger mask write.
// Depends on kde_pkg for field widths.
interface kde_scan_if;
    logic                      valid;
    logic                      ready;
    logic [kde_pkg::CODE_W-1:0] scan_code;

    modport source (output valid, output scan_code, input ready);
    modport sink   (input valid, input scan_code, output ready);
endinterface

interface kde_event_if;
    logic                      valid;
    logic                      ready;
    logic [kde_pkg::KIND_W-1:0] event_kind;
    logic [kde_pkg::CODE_W-1:0] key_code;

    modport source (output valid, output event_kind, output key_code, input ready);
    modport sink   (input valid, input event_kind, input key_code, output ready);
endinterface

interface kde_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [kde_pkg::MASK_W-1:0] trigger_mask;

    modport source (output valid, output trigger_mask, input ready);
    modport sink   (input valid, input trigger_mask, output ready);
endinterface

[rtl/kde_fsm.sv]
// Debounce state machine with filtered and reported code registers.
// Advances one scan per step strobe; depends on kde_pkg.
module kde_fsm (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [kde_pkg::CODE_W-1:0]  code,
    input  logic [kde_pkg::MASK_W-1:0]  mask,
    output kde_pkg::kde_event_t         evt
);
    import kde_pkg::*;

    kde_state_t        state_reg, state_next;
    logic [CODE_W-1:0] filt_reg, filt_next;
    logic [CODE_W-1:0] rep_reg, rep_next;
    logic              zero, same;

    assign zero = (code == '0);
    assign same = (code == filt_reg);

    always_comb
    begin
        state_next = state_reg;
        filt_next  = filt_reg;
        unique case (state_reg)
            ST_PRESS_FILT, ST_PRESS_EDGE, ST_PRESSED:
            begin
                if (!zero && same)
                begin
                    if (state_reg != ST_PRESSED)
                        state_next = (state_reg == ST_PRESS_FILT) ? ST_PRESS_EDGE : ST_PRESSED;
                end
                else
                begin
                    filt_next  = code;
                    state_next = zero ? ST_REL_FILT : ST_PRESS_FILT;
                end
            end
            ST_REL_FILT, ST_REL_EDGE, ST_RELEASED:
            begin
                if (zero)
                begin
                    if (state_reg != ST_RELEASED)
                        state_next = (state_reg == ST_REL_FILT) ? ST_REL_EDGE : ST_RELEASED;
                end
                else
                begin
                    filt_next  = code;
                    state_next = ST_PRESS_FILT;
                end
            end
            default:
            begin
                filt_next  = code;
                state_next = zero ? ST_REL_FILT : ST_PRESS_FILT;
            end
        endcase
    end

    always_comb
    begin
        evt.valid = 1'b0;
        evt.kind  = EV_PRESS_HOLD;
        evt.code  = code;
        rep_next  = rep_reg;
        unique case (state_reg)
            ST_PRESS_EDGE:
            begin
                if (!zero && same)
                begin
                    if (rep_reg != code && mask[MB_PRESS_EDGE])
                    begin
                        evt.valid = 1'b1;
                        evt.kind  = EV_PRESS_EDGE;
                        rep_next  = code;
                    end
                    else if (rep_reg == code && mask[MB_PRESS_HOLD])
                    begin
                        evt.valid = 1'b1;
                        evt.kind  = EV_PRESS_HOLD;
                    end
                end
            end
            ST_PRESSED:
            begin
                if (!zero && same && mask[MB_PRESS_HOLD])
                begin
                    evt.valid = 1'b1;
                    evt.kind  = EV_PRESS_HOLD;
                end
            end
            ST_REL_EDGE:
            begin
                if (zero && rep_reg != '0 && mask[MB_REL_EDGE])
                begin
                    evt.valid = 1'b1;
                    evt.kind  = EV_REL_EDGE;
                    rep_next  = '0;
                end
            end
            ST_RELEASED:
            begin
                if (zero && mask[MB_REL_HOLD])
                begin
                    evt.valid = 1'b1;
                    evt.kind  = EV_REL_HOLD;
                end
            end
            default:
            begin
                evt.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            filt_reg  <= '0;
            rep_reg   <= '0;
        end
        else if (step)
        begin
            state_reg <= state_next;
            filt_reg  <= filt_next;
            rep_reg   <= rep_next;
        end
    end

endmodule

[rtl/key_debounce_event_fsm_top.sv]
// Top level of the key debounce event machine: input register, state
// machine and result register. Depends on kde_pkg, kde_if and kde_fsm.
//
//   port   dir   payload         meaning
//   scan   in    scan_code[7:0]  one scan sample per transfer
//   evt    out   event_kind[1:0] press/release edge or hold event
//                key_code[7:0]
//   cfg    in    trigger_mask[3:0] event enable bits
//
// One scan per cycle sustained while evt is not stalled; a scan's event is
// offered on evt once it has passed the input register, loaded at the
// transfer, and then the state machine into the result register.
// A scan that raises no event produces no output transfer.
// A stall on evt holds the result register and the input register; scan is
// taken again as soon as the input register drains. Reset clears state,
// filtered and reported codes, mask and valid flags.
module key_debounce_event_fsm_top (
    input  logic              clk,
    input  logic              rst_n,
    kde_scan_if.sink          scan,
    kde_event_if.source       evt,
    kde_cfg_if.sink           cfg
);
    import kde_pkg::*;

    logic              in_valid_reg;
    logic [CODE_W-1:0] in_code_reg;
    logic [MASK_W-1:0] mask_reg;
    logic              out_valid_reg;
    kde_kind_t         out_kind_reg;
    logic [CODE_W-1:0] out_code_reg;
    logic              advance;
    kde_event_t        step_evt;

    assign advance    = in_valid_reg && (!out_valid_reg || evt.ready);
    assign scan.ready = !in_valid_reg || advance;
    assign cfg.ready  = 1'b1;

    kde_fsm u_fsm (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .code  (in_code_reg),
        .mask  (mask_reg),
        .evt   (step_evt)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mask_reg      <= '0;
        end
        else
        begin
            if (scan.ready)
                in_valid_reg <= scan.valid;
            if (advance)
                out_valid_reg <= step_evt.valid;
            else if (evt.ready)
                out_valid_reg <= 1'b0;
            if (cfg.valid)
                mask_reg <= cfg.trigger_mask;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan.valid && scan.ready)
            in_code_reg <= scan.scan_code;
        if (advance)
        begin
            out_kind_reg <= step_evt.kind;
            out_code_reg <= step_evt.code;
        end
    end

    assign evt.valid      = out_valid_reg;
    assign evt.event_kind = out_kind_reg;
    assign evt.key_code   = out_code_reg;

endmodule
